[sv/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg
// shared types and constants for the subset sum reachability block
// ----------------------------------------------------------------------------
package ssr_pkg;

    // default sizes
    localparam int SUM_WINDOW_DEF = 1024;
    localparam int VALUE_BITS_DEF = 8;
    localparam int TARGET_BITS    = 10;
    localparam int QUEUE_DEPTH    = 2;

    // classification of one item, made by the front end
    typedef struct packed {
        logic neg;
        logic last;
    } ssr_class_t;

    // one result item
    typedef struct packed {
        logic reachable;
        logic window_exceeded;
        logic set_done;
    } ssr_result_t;

endpackage

[sv/ssr_fifo.sv]
// ----------------------------------------------------------------------------
// ssr_fifo
// small first-word-fall-through queue in flops, power-of-two depth
// ----------------------------------------------------------------------------
module ssr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ssr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointers wrap naturally at a power-of-two depth
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/ssr_front.sv]
// ----------------------------------------------------------------------------
// ssr_front
// accepts items, splits the value into sign and magnitude, queues them
// ----------------------------------------------------------------------------
module ssr_front #(
    parameter int VALUE_BITS = ssr_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last,
    output logic                         cmd_valid,
    input  logic                         cmd_pop,
    output logic [VALUE_BITS-1:0]        cmd_mag,
    output ssr_pkg::ssr_class_t          cmd_class
);

    localparam int CLS_W = $bits(ssr_pkg::ssr_class_t);
    localparam int Q_W   = CLS_W + VALUE_BITS;

    ssr_pkg::ssr_class_t   cls;
    logic [VALUE_BITS-1:0] mag;
    logic [Q_W-1:0]        q_wdata;
    logic [Q_W-1:0]        q_rdata;
    logic                  q_empty;

    // magnitude of the most negative value still fits unsigned
    always_comb
    begin
        cls.neg  = value[VALUE_BITS-1];
        cls.last = last;
        mag      = cls.neg ? VALUE_BITS'(-value) : VALUE_BITS'(value);
        q_wdata  = {cls, mag};
    end

    ssr_fifo #(
        .WIDTH (Q_W),
        .DEPTH (ssr_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd_mag   = q_rdata[VALUE_BITS-1:0];
    assign cmd_class = ssr_pkg::ssr_class_t'(q_rdata[Q_W-1:VALUE_BITS]);

endmodule

[sv/ssr_back.sv]
// ----------------------------------------------------------------------------
// ssr_back
// bitset engine: shift-and-or of the whole window, totals and target test
// ----------------------------------------------------------------------------
module ssr_back #(
    parameter int SUM_WINDOW = ssr_pkg::SUM_WINDOW_DEF,
    parameter int VALUE_BITS = ssr_pkg::VALUE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_pop,
    input  logic [VALUE_BITS-1:0]                 in_mag,
    input  ssr_pkg::ssr_class_t                   in_class,
    input  logic signed [ssr_pkg::TARGET_BITS-1:0] target,
    input  logic                                  out_full,
    output logic                                  out_push,
    output ssr_pkg::ssr_result_t                  out_result
);

    localparam int LOG_W = $clog2(SUM_WINDOW);
    localparam int HALF  = SUM_WINDOW / 2;
    localparam int TOT_W = LOG_W + 1;
    localparam int WIDE0 = (LOG_W > VALUE_BITS) ? LOG_W : VALUE_BITS;
    localparam int IDX_W = ((WIDE0 > ssr_pkg::TARGET_BITS) ? WIDE0 : ssr_pkg::TARGET_BITS) + 2;
    localparam int SUM_W = ((TOT_W > VALUE_BITS) ? TOT_W : VALUE_BITS) + 1;

    logic [SUM_WINDOW-1:0]   bits_reg, bits_next;
    logic [SUM_WINDOW-1:0]   shifted;
    logic [SUM_WINDOW-1:0]   single;
    logic [SUM_WINDOW-1:0]   new_bits;
    logic [TOT_W-1:0]        pos_reg, pos_next, pos_new;
    logic [TOT_W-1:0]        neg_reg, neg_next, neg_new;
    logic                    ovf_reg, ovf_next, ovf_new;
    logic [SUM_W-1:0]        pos_sum;
    logic [SUM_W-1:0]        neg_sum;
    logic signed [IDX_W-1:0] val_s;
    logic signed [IDX_W-1:0] val_idx;
    logic signed [IDX_W-1:0] tgt_idx;
    logic                    val_in;
    logic                    tgt_in;
    logic                    fire;

    assign fire     = in_valid && !out_full;
    assign in_pop   = fire;
    assign out_push = fire;

    always_comb
    begin
        // window positions of the value itself and of the target
        val_s = IDX_W'(in_mag);
        if (in_class.neg)
        begin
            val_s = -val_s;
        end
        val_idx = val_s + IDX_W'(HALF);
        tgt_idx = IDX_W'(target) + IDX_W'(HALF);
        val_in  = (val_idx >= 0) && (val_idx < IDX_W'(SUM_WINDOW));
        tgt_in  = (tgt_idx >= 0) && (tgt_idx < IDX_W'(SUM_WINDOW));

        // shift toward higher sums for a positive value, lower for negative
        shifted  = in_class.neg ? (bits_reg >> in_mag) : (bits_reg << in_mag);
        single   = val_in ? (SUM_WINDOW'(1) << val_idx[LOG_W-1:0]) : '0;
        new_bits = bits_reg | shifted | single;

        // saturating running totals
        pos_sum = SUM_W'(pos_reg) + SUM_W'(in_mag);
        neg_sum = SUM_W'(neg_reg) + SUM_W'(in_mag);
        pos_new = pos_reg;
        neg_new = neg_reg;
        if (in_class.neg)
        begin
            neg_new = (neg_sum > SUM_W'(SUM_WINDOW)) ? TOT_W'(SUM_WINDOW) : neg_sum[TOT_W-1:0];
        end
        else
        begin
            pos_new = (pos_sum > SUM_W'(SUM_WINDOW)) ? TOT_W'(SUM_WINDOW) : pos_sum[TOT_W-1:0];
        end
        ovf_new = ovf_reg || (pos_new > TOT_W'(HALF - 1)) || (neg_new > TOT_W'(HALF));

        out_result.reachable       = tgt_in && new_bits[tgt_idx[LOG_W-1:0]];
        out_result.window_exceeded = ovf_new;
        out_result.set_done        = in_class.last;

        bits_next = bits_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        if (fire)
        begin
            if (in_class.last)
            begin
                bits_next = '0;
                pos_next  = '0;
                neg_next  = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                bits_next = new_bits;
                pos_next  = pos_new;
                neg_next  = neg_new;
                ovf_next  = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            pos_reg  <= '0;
            neg_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            pos_reg  <= pos_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
        end
    end

    // set state is empty after a closing item
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_class.last |=> (bits_reg == '0) && !ovf_reg && (pos_reg == '0))
        else $error("set state not cleared after last item");

    // window flag holds until the set closes
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(fire && in_class.last) |=> ovf_reg)
        else $error("window flag dropped inside a set");

    // totals saturate at the window size
    a_totals_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= TOT_W'(SUM_WINDOW)) && (neg_reg <= TOT_W'(SUM_WINDOW)))
        else $error("running total above saturation");

    // a reported flag agrees with the stored flag once written
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !in_class.last |=> ovf_reg == $past(out_result.window_exceeded))
        else $error("stored window flag differs from reported one");

endmodule

[sv/subset_sum_reachability.sv]
// ----------------------------------------------------------------------------
// subset_sum_reachability
// streaming subset sum reachability over a signed window of sums
// ----------------------------------------------------------------------------
// path: command queue, then bitset engine, then result queue (empty low)
// throughput: one item per cycle while the result queue has room; the whole
// window shift-and-or is combinational in the engine, which sets the rate
// reset: asynchronous active low; queues empty, bitset and totals zero,
// target register zero
module subset_sum_reachability #(
    parameter int SUM_WINDOW = ssr_pkg::SUM_WINDOW_DEF,
    parameter int VALUE_BITS = ssr_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration: target sum
    input  logic                                   cfg_we,
    input  logic signed [ssr_pkg::TARGET_BITS-1:0] cfg_data,
    // item input
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [VALUE_BITS-1:0]           value,
    input  logic                                   last,
    // result output
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   reachable,
    output logic                                   window_exceeded,
    output logic                                   set_done
);

    localparam int RES_W = $bits(ssr_pkg::ssr_result_t);

    // target register: user writes only while block is idle; not enforced
    logic signed [ssr_pkg::TARGET_BITS-1:0] target_reg;
    logic signed [ssr_pkg::TARGET_BITS-1:0] target_next;

    // front to back
    logic                  cmd_valid;
    logic                  cmd_pop;
    logic [VALUE_BITS-1:0] cmd_mag;
    ssr_pkg::ssr_class_t   cmd_class;

    // back to result queue
    logic                  res_full;
    logic                  res_push;
    ssr_pkg::ssr_result_t  res_item;
    ssr_pkg::ssr_result_t  res_head;
    logic [RES_W-1:0]      res_rdata;

    assign target_next = cfg_we ? cfg_data : target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    // front end: take items, split into sign and magnitude, queue them
    ssr_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_mag   (cmd_mag),
        .cmd_class (cmd_class)
    );

    // back end: one item per cycle into the bitset whenever results have room
    ssr_back #(
        .SUM_WINDOW (SUM_WINDOW),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_valid),
        .in_pop     (cmd_pop),
        .in_mag     (cmd_mag),
        .in_class   (cmd_class),
        .target     (target_reg),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_result (res_item)
    );

    // result queue parts the engine from the consumer
    ssr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ssr_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // oldest waiting result on the ports
    assign res_head        = ssr_pkg::ssr_result_t'(res_rdata);
    assign reachable       = res_head.reachable;
    assign window_exceeded = res_head.window_exceeded;
    assign set_done        = res_head.set_done;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams signed set elements into the subset sum block and checks every
// result against a bitset predictor kept in step with the accepted items
// ----------------------------------------------------------------------------
module tb;

    localparam int VBITS       = ssr_pkg::VALUE_BITS_DEF;
    localparam int TBITS       = ssr_pkg::TARGET_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 300;

    // ------------------------------------------------------------------------
    // expected results: a bitset of reachable sums, the running totals and the
    // sticky window flag, updated on every accepted item
    // ------------------------------------------------------------------------
    class reach_scoreboard;
        localparam int WIN  = ssr_pkg::SUM_WINDOW_DEF;
        localparam int HALF = ssr_pkg::SUM_WINDOW_DEF / 2;

        logic [WIN-1:0]               sums_seen;
        logic [10:0]                  pos_total;
        logic [10:0]                  neg_total;
        logic                         overflow;
        logic signed [TBITS-1:0]      target;
        ssr_pkg::ssr_result_t         expected_q[$];
        int                           errors;

        function new();
            clear_set();
            target = '0;
            errors = 0;
        endfunction

        function void clear_set();
            sums_seen = '0;
            pos_total = '0;
            neg_total = '0;
            overflow  = 1'b0;
        endfunction

        function void set_target(logic signed [TBITS-1:0] t);
            target = t;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted element: totals, shift-and-or, then the target test
        function void note_item(logic signed [VBITS-1:0] v, logic is_last);
            logic [WIN-1:0]       moved;
            int                   mag;
            int                   sum_t;
            int                   idx;
            ssr_pkg::ssr_result_t r;
            if (v < 0) begin
                mag   = -int'(v);
                sum_t = int'(neg_total) + mag;
                neg_total = (sum_t > WIN) ? 11'(WIN) : 11'(sum_t);
            end
            else begin
                mag   = int'(v);
                sum_t = int'(pos_total) + mag;
                pos_total = (sum_t > WIN) ? 11'(WIN) : 11'(sum_t);
            end
            if (int'(pos_total) > HALF - 1 || int'(neg_total) > HALF)
                overflow = 1'b1;
            // sums shifted out of the window are lost for good
            if (mag >= WIN)
                moved = '0;
            else if (v < 0)
                moved = sums_seen >> mag;
            else
                moved = sums_seen << mag;
            sums_seen = sums_seen | moved;
            // the element on its own
            idx = int'(v) + HALF;
            if (idx >= 0 && idx < WIN)
                sums_seen[idx] = 1'b1;
            idx = int'(target) + HALF;
            r.reachable       = (idx >= 0 && idx < WIN) ? sums_seen[idx] : 1'b0;
            r.window_exceeded = overflow;
            r.set_done        = is_last;
            expected_q.push_back(r);
            if (is_last)
                clear_set();
        endfunction

        function void check_result(logic got_reach, logic got_win, logic got_done);
            ssr_pkg::ssr_result_t e;
            if (expected_q.size() == 0) begin
                $error({"result with nothing expected: ",
                        "reachable %0b window_exceeded %0b set_done %0b"},
                       got_reach, got_win, got_done);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got_reach !== e.reachable) begin
                $error("reachable: expected %0b, got %0b", e.reachable, got_reach);
                errors++;
            end
            if (got_win !== e.window_exceeded) begin
                $error("window_exceeded: expected %0b, got %0b", e.window_exceeded, got_win);
                errors++;
            end
            if (got_done !== e.set_done) begin
                $error("set_done: expected %0b, got %0b", e.set_done, got_done);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic signed [TBITS-1:0]        cfg_data = '0;
    logic                           push     = 1'b0;
    logic                           full;
    logic signed [VBITS-1:0]        value    = '0;
    logic                           last     = 1'b0;
    logic                           empty;
    logic                           pop      = 1'b0;
    logic                           reachable;
    logic                           window_exceeded;
    logic                           set_done;

    subset_sum_reachability dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .value           (value),
        .last            (last),
        .empty           (empty),
        .pop             (pop),
        .reachable       (reachable),
        .window_exceeded (window_exceeded),
        .set_done        (set_done)
    );

    reach_scoreboard sb = new();

    // idle rates in percent, changed by the stimulus between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off, driven by its own counting process
    logic hold_on     = 1'b0;
    int   cycle_count = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("subset_sum_reachability: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: check every popped item, then pick the next pop value
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_result(reachable, window_exceeded, set_done);
            if (hold_on)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------------

    // offer one element, with an optional gap first; push stays high after
    // acceptance so that back to back items need no toggle
    task automatic send_item(input logic signed [VBITS-1:0] v, input logic is_last);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = (send_idle_pct > 50) ? $urandom_range(1, 5) : 1;
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        last  <= is_last;
        do
            @(posedge clk);
        while (full);
        sb.note_item(v, is_last);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // target write, only with the block idle
    task automatic write_target(input logic signed [TBITS-1:0] t);
        cfg_we   <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_target(t);
    endtask

    // random sets with random content; a few sets run on without a last
    // marker so that state carries across into the next set
    task automatic send_random_sets(input int n_items);
        int sent;
        int set_len;
        int flavor;
        logic signed [VBITS-1:0] v;
        logic is_last;
        sent = 0;
        while (sent < n_items) begin
            flavor = $urandom_range(9);
            set_len = (flavor >= 8) ? $urandom_range(3, 9) : $urandom_range(1, 10);
            for (int i = 0; i < set_len; i++) begin
                case (flavor) inside
                    [0:3]:   v = VBITS'($urandom_range(255));
                    [4:7]:   v = VBITS'(int'($urandom_range(32)) - 16);
                    8:       v = VBITS'($urandom_range(100, 127));
                    default: v = VBITS'(-int'($urandom_range(100, 128)));
                endcase
                is_last = (i == set_len - 1) && ($urandom_range(9) != 0);
                send_item(v, is_last);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_items,
                             input logic signed [TBITS-1:0] t);
        drain();
        write_target(t);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        send_random_sets(n_items);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset target of zero, zero element alone
        send_item(8'sd0, 1'b1);
        // opposite elements cancel to zero
        send_item(-8'sd1, 1'b0);
        send_item(8'sd1, 1'b1);

        // most negative target, reached exactly at the edge of the window
        drain();
        write_target(-10'sd512);
        repeat (4) send_item(-8'sd128, 1'b0);
        send_item(-8'sd128, 1'b1);

        // most positive target, reached with the positive total at its limit
        drain();
        write_target(10'sd511);
        repeat (4) send_item(8'sd127, 1'b0);
        send_item(8'sd3, 1'b0);
        send_item(8'sd127, 1'b1);

        // mixed signs, then partial sums pushed out of the window and lost
        drain();
        write_target(10'sd100);
        send_item(8'sd127, 1'b0);
        send_item(-8'sd27, 1'b1);
        repeat (5) send_item(8'sd127, 1'b0);
        send_item(-8'sd128, 1'b0);
        send_item(-8'sd128, 1'b0);
        send_item(8'sd101, 1'b1);

        // random phases over the idling styles and the target extremes
        run_phase(0, 0, 100, 10'sd7);
        run_phase(68, 0, 100, -10'sd512);
        run_phase(0, 68, 100, 10'sd511);
        run_phase(20, 20, 100, TBITS'(int'($urandom_range(80)) - 40));
        run_phase(0, 0, 100, TBITS'($urandom_range(1023)));

        // receiver holds off while the sender keeps offering: queue fills up
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        send_random_sets(40);

        run_phase(68, 0, 100, TBITS'(int'($urandom_range(60)) - 30));
        run_phase(0, 68, 100, 10'sd0);
        run_phase(20, 20, 100, TBITS'(int'($urandom_range(200)) - 100));

        drain();
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("subset_sum_reachability: match");
        else
            $display("subset_sum_reachability: mismatch");
        $finish;
    end

endmodule
